@@ hw/rtl/rtds_pkg.sv @@
// shared types and codes for the record table block
package rtds_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SORT   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // status codes of a result item
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // fixed field widths
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COUNT_W = 7;

    // one stored record
    typedef struct packed {
        logic [7:0]  key;
        logic [63:0] tail;
        logic [7:0]  age;
    } t_record;

endpackage

@@ hw/rtl/rtds_if.sv @@
// item and result channel interfaces of the record table block

// input item channel
interface rtds_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  position;
    logic [7:0]  key_char;
    logic [63:0] name_tail;
    logic [7:0]  age_value;

    modport source (output valid, operation, position, key_char, name_tail, age_value,
                    input ready);
    modport sink (input valid, operation, position, key_char, name_tail, age_value,
                  output ready);
endinterface

// result item channel
interface rtds_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [7:0]  read_key;
    logic [63:0] read_tail;
    logic [7:0]  read_age;

    modport source (output valid, status, entry_count, read_key, read_tail, read_age,
                    input ready);
    modport sink (input valid, status, entry_count, read_key, read_tail, read_age,
                  output ready);
endinterface

@@ hw/rtl/rtds_mem.sv @@
// record memory: one write port, one registered read port
module rtds_mem #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned AW = 4
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  rtds_pkg::t_record  i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output rtds_pkg::t_record  o_rdata
);

    rtds_pkg::t_record r_mem [CAPACITY];
    rtds_pkg::t_record r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/record_table_delete_and_sort_top.sv @@
// Record table top level: sequencer around one record memory and one key comparator.
// Append and rejected items go straight to the result; a read fetches its record first,
// delete shifts each later entry down one place, sort makes a pivot pass per later entry.
// One item at a time: the memory ports are shared by every step, so the next item is
// taken when the sequencer is back at rest; a result may wait in the output register.
// Synchronous active-low reset empties the table and clears the handshake state.
module record_table_delete_and_sort_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rtds_item_if.sink            i_item,
    rtds_result_if.source        o_result
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_DRD  = 10'b0000000100,
        S_DWR  = 10'b0000001000,
        S_SLD  = 10'b0000010000,
        S_SPV  = 10'b0000100000,
        S_SRD  = 10'b0001000000,
        S_SCMP = 10'b0010000000,
        S_SWB  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_x, n_x;
    rtds_pkg::t_record r_pivot, n_pivot;
    logic [1:0]        r_res_status, n_res_status;
    rtds_pkg::t_record r_res_rec, n_res_rec;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    logic [6:0]        r_out_count, n_out_count;
    rtds_pkg::t_record r_out_rec, n_out_rec;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    rtds_pkg::t_record mem_wdata;
    logic [AW-1:0]     mem_raddr;
    rtds_pkg::t_record mem_rdata;

    logic              in_fire;
    logic              out_free;
    logic [7:0]        pos_ext;
    logic [7:0]        count_ext;
    logic              i_more;
    logic              x_more;

    // record memory
    rtds_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // handshake and loop bounds
    assign i_item.ready = (r_state == S_IDLE);
    assign in_fire      = i_item.valid && (r_state == S_IDLE);
    assign out_free     = !r_out_valid || o_result.ready;
    assign pos_ext      = {2'b00, i_item.position};
    assign count_ext    = 8'(r_count);
    assign i_more       = ({1'b0, r_i} + 1'b1) < {1'b0, r_count};
    assign x_more       = ({1'b0, r_x} + 1'b1) < {1'b0, r_count};

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_i          = r_i;
        n_x          = r_x;
        n_pivot      = r_pivot;
        n_res_status = r_res_status;
        n_res_rec    = r_res_rec;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_rec    = r_out_rec;
        mem_we       = 1'b0;
        mem_waddr    = r_count[AW-1:0];
        mem_wdata    = r_pivot;
        mem_raddr    = r_i[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_status = rtds_pkg::ST_OK;
                    n_res_rec    = '0;
                    n_state      = S_DONE;
                    unique case (i_item.operation)
                        rtds_pkg::OP_APPEND: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_res_status = rtds_pkg::ST_FULL;
                            end else begin
                                mem_we         = 1'b1;
                                mem_waddr      = r_count[AW-1:0];
                                mem_wdata.key  = i_item.key_char;
                                mem_wdata.tail = i_item.name_tail;
                                mem_wdata.age  = i_item.age_value;
                                n_count        = r_count + 1'b1;
                            end
                        end
                        rtds_pkg::OP_DELETE: begin
                            if (r_count == '0 || i_item.position == '0 ||
                                pos_ext > count_ext) begin
                                n_res_status = rtds_pkg::ST_BAD;
                            end else begin
                                n_i     = CW'(pos_ext - 8'd1);
                                n_state = S_DRD;
                            end
                        end
                        rtds_pkg::OP_SORT: begin
                            n_i     = CW'(1);
                            n_state = S_SLD;
                        end
                        default: begin
                            if (pos_ext >= count_ext) begin
                                n_res_status = rtds_pkg::ST_RANGE;
                            end else begin
                                mem_raddr = i_item.position[AW-1:0];
                                n_state   = S_RD;
                            end
                        end
                    endcase
                end
            end
            // read data back from memory
            S_RD: begin
                n_res_rec = mem_rdata;
                n_state   = S_DONE;
            end
            // delete: fetch the next entry or finish
            S_DRD: begin
                if (i_more) begin
                    mem_raddr = AW'(r_i + 1'b1);
                    n_state   = S_DWR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            // delete: shift it down one place
            S_DWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[AW-1:0];
                mem_wdata = mem_rdata;
                n_i       = r_i + 1'b1;
                n_state   = S_DRD;
            end
            // sort: fetch record i into the pivot register
            S_SLD: begin
                if (r_i < r_count) begin
                    mem_raddr = r_i[AW-1:0];
                    n_state   = S_SPV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SPV: begin
                n_pivot = mem_rdata;
                n_x     = '0;
                n_state = S_SRD;
            end
            // sort: fetch record x
            S_SRD: begin
                if (x_more) begin
                    mem_raddr = r_x[AW-1:0];
                    n_state   = S_SCMP;
                end else begin
                    n_state = S_SWB;
                end
            end
            // sort: compare keys, swap x with the pivot when x is larger and x is not i
            S_SCMP: begin
                if (r_x != r_i && mem_rdata.key > r_pivot.key) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_x[AW-1:0];
                    mem_wdata = r_pivot;
                    n_pivot   = mem_rdata;
                end
                n_x     = r_x + 1'b1;
                n_state = S_SRD;
            end
            // sort: write the pivot back to place i
            S_SWB: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[AW-1:0];
                mem_wdata = r_pivot;
                n_i       = r_i + 1'b1;
                n_state   = S_SLD;
            end
            // hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_count  = 7'(r_count);
                    n_out_rec    = r_res_rec;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_x          <= n_x;
        r_pivot      <= n_pivot;
        r_res_status <= n_res_status;
        r_res_rec    <= n_res_rec;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_rec    <= n_out_rec;
    end

    // result channel
    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.entry_count = r_out_count;
    assign o_result.read_key    = r_out_rec.key;
    assign o_result.read_tail   = r_out_rec.tail;
    assign o_result.read_age    = r_out_rec.age;

endmodule

@@ hw/rtl/rtds_check.sv @@
// port-level checker for the record table block, bound to the top level
module rtds_check #(
    parameter int unsigned CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [6:0]  i_entry_count,
    input logic [7:0]  i_read_key,
    input logic [63:0] i_read_tail,
    input logic [7:0]  i_read_age
);

    // a stalled result holds its status, entry count and tail
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status) &&
        $stable(i_entry_count) && $stable(i_read_tail)))
        else $error("result changed while stalled");

    // count never passes the capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_entry_count <= 7'(CAPACITY)))
        else $error("entry count above capacity");

    // full status only with a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == rtds_pkg::ST_FULL) |-> (i_entry_count == 7'(CAPACITY)))
        else $error("full status with room left");

    // read fields are zero on a failed item
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == rtds_pkg::ST_RANGE || i_status == rtds_pkg::ST_BAD ||
        i_status == rtds_pkg::ST_FULL)) |-> (i_read_key == '0 && i_read_tail == '0 &&
        i_read_age == '0))
        else $error("read fields set on a failed item");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind record_table_delete_and_sort_top rtds_check #(
    .CAPACITY (CAPACITY)
) u_rtds_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_entry_count (o_result.entry_count),
    .i_read_key    (o_result.read_key),
    .i_read_tail   (o_result.read_tail),
    .i_read_age    (o_result.read_age)
);
